// ----- rtl/ptam_pkg.sv -----
`default_nettype none
package ptam_pkg;

  // Second-level pool geometry
  localparam int unsigned L2_TABLES  = 8;
  localparam int unsigned TBL_W      = (L2_TABLES > 1) ? $clog2(L2_TABLES) : 1;
  localparam int unsigned ALLOC_W    = $clog2(L2_TABLES + 1);
  localparam int unsigned L1_AW      = 12;
  localparam int unsigned L2_AW      = TBL_W + 8;
  localparam int unsigned CLR_W      = (L2_AW > L1_AW) ? L2_AW : L1_AW;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNALIGN = 2'd1;
  localparam logic [1:0] ST_NOPOOL  = 2'd2;
  localparam logic [1:0] ST_CLASH   = 2'd3;

  // Walk kinds
  localparam logic [2:0] WK_L1_NONE  = 3'd0;
  localparam logic [2:0] WK_COARSE   = 3'd1;
  localparam logic [2:0] WK_SECTION  = 3'd2;
  localparam logic [2:0] WK_RESERVED = 3'd3;
  localparam logic [2:0] WK_L2_NONE  = 3'd4;
  localparam logic [2:0] WK_LARGE    = 3'd5;
  localparam logic [2:0] WK_PAGE     = 3'd6;

  // Descriptor type codes (low two bits)
  localparam logic [1:0] DT_FAULT  = 2'd0;
  localparam logic [1:0] DT_COARSE = 2'd1;

  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [31:0] area_size;
    logic [2:0]  mem_type;
    logic [1:0]  access;
    logic        no_exec;
    logic        shared_flag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] remaining_size;
    logic [2:0]  walk_kind;
    logic [31:0] l1_descriptor;
    logic [31:0] l2_descriptor;
  } rsp_t;

  function automatic logic [1:0] tex_of(input logic [2:0] mt);
    logic [1:0] r;
    unique case (mt)
      3'd1, 3'd5, 3'd6: r = 2'd1;
      3'd3:             r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cb_of(input logic [2:0] mt);
    logic [1:0] r;
    unique case (mt)
      3'd2:       r = 2'd1;
      3'd4:       r = 2'd2;
      3'd5, 3'd6: r = 2'd3;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  // AP[2] lands five bits above AP[1:0]
  function automatic logic [5:0] ap_of(input logic [1:0] acc);
    logic [5:0] r;
    unique case (acc)
      2'd1:    r = 6'h21;
      2'd2:    r = 6'h01;
      default: r = 6'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ptam_if.sv -----
`default_nettype none
interface ptam_req_if;
  import ptam_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ptam_rsp_if;
  import ptam_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/page_table_area_mapper.sv -----
// Channel   Dir  Word
// req_i     in   ptam_pkg::req_t  map or walk request
// rsp_o     out  ptam_pkg::rsp_t  status, remainder, walk result
// cfg_*     in   32-bit pool base, written when cfg_we_i is high
//
// Reset starts a clearing pass that steps a CLR_W-bit counter over every
// address of both tables; no request is taken until it ends.
// A map is accepted in S_IDLE; each section is written in S_STEP, and each
// page reads the first-level table in S_STEP and writes in S_PG_L1; an
// S_STEP with no size left ends it (a failing page ends in S_PG_L1). A walk
// passes S_RD_L1 and S_RD_L2, and S_RD_FIN too through a coarse pool entry.
// Pace is set by the single read and write port of each table.
// One request at a time; the result word holds until rsp_o.ready.
`default_nettype none
module page_table_area_mapper import ptam_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ptam_req_if.sink         req_i,
  ptam_rsp_if.source       rsp_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_STEP   = 7'b0000100,
    S_PG_L1  = 7'b0001000,
    S_RD_L1  = 7'b0010000,
    S_RD_L2  = 7'b0100000,
    S_RD_FIN = 7'b1000000
  } state_e;

  localparam int unsigned L2_DEPTH = 2 ** L2_AW;

  state_e state_q, state_d;
  logic             done_q, done_d;
  logic [CLR_W-1:0] clr_q, clr_d;
  logic [ALLOC_W-1:0] alloc_q, alloc_d;
  logic [31:0]      base_q;
  req_t             r_q, r_d;
  rsp_t             out_q, out_d;

  logic [31:0] l1_mem [2**L1_AW];
  logic [31:0] l2_mem [L2_DEPTH];
  logic [31:0] l1_rd_q, l2_rd_q;

  logic             l1_we, l2_we;
  logic [L1_AW-1:0] l1_wa;
  logic [L2_AW-1:0] l2_wa, l2_ra;
  logic [31:0]      l1_wd, l2_wd;

  // Descriptor attribute bits
  logic [31:0] sect_bits, page_bits, all_bits, pool_al, alloc_addr;
  logic [5:0]  ap_bits;
  logic [21:0] off;
  logic        in_pool;

  assign ap_bits   = ap_of(r_q.access);
  assign sect_bits = {15'd0, r_q.shared_flag, ap_bits[5], 1'b0, tex_of(r_q.mem_type),
                      1'b0, ap_bits[0], 5'd0, r_q.no_exec, cb_of(r_q.mem_type), 2'b10};
  assign page_bits = {21'd0, r_q.shared_flag, ap_bits[5], 1'b0, tex_of(r_q.mem_type),
                      1'b0, ap_bits[0], cb_of(r_q.mem_type), 1'b1, r_q.no_exec};
  assign all_bits  = r_q.virt_addr | r_q.phys_addr | r_q.area_size;
  assign pool_al   = {base_q[31:10], 10'd0};
  assign alloc_addr = pool_al + {{(22 - ALLOC_W){1'b0}}, alloc_q, 10'd0};

  // Table index named by the fetched first-level entry
  assign off     = l1_rd_q[31:10] - base_q[31:10];
  assign in_pool = off < 22'(L2_TABLES);
  assign l2_ra   = {off[TBL_W-1:0], r_q.virt_addr[19:12]};

  // Sequencer
  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    clr_d   = clr_q;
    alloc_d = alloc_q;
    r_d     = r_q;
    out_d   = out_q;
    l1_we   = 1'b0;
    l1_wa   = r_q.virt_addr[31:20];
    l1_wd   = r_q.phys_addr | sect_bits;
    l2_we   = 1'b0;
    l2_wa   = {off[TBL_W-1:0], r_q.virt_addr[19:12]};
    l2_wd   = r_q.phys_addr | page_bits;
    if (done_q && rsp_o.ready) begin
      done_d  = 1'b0;
      state_d = S_IDLE;
    end
    unique case (state_q)
      S_CLEAR: begin
        l1_we = 1'b1;
        l1_wa = clr_q[L1_AW-1:0];
        l1_wd = '0;
        l2_we = 1'b1;
        l2_wa = clr_q[L2_AW-1:0];
        l2_wd = '0;
        clr_d = clr_q + 1'b1;
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_i.valid && !done_q) begin
          r_d     = req_i.payload;
          state_d = (req_i.payload.func == FUNC_READ) ? S_RD_L1 : S_STEP;
        end
      end
      S_STEP: begin
        out_d = '{status: ST_OK, remaining_size: r_q.area_size,
                  walk_kind: WK_L1_NONE, l1_descriptor: '0, l2_descriptor: '0};
        if (r_q.area_size == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (all_bits[19:0] == '0) begin
          l1_we = 1'b1;
          r_d.virt_addr = r_q.virt_addr + 32'h0010_0000;
          r_d.phys_addr = r_q.phys_addr + 32'h0010_0000;
          r_d.area_size = r_q.area_size - 32'h0010_0000;
        end else if (all_bits[11:0] == '0) begin
          state_d = S_PG_L1;
        end else begin
          out_d.status = ST_UNALIGN;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PG_L1: begin
        out_d = '{status: ST_CLASH, remaining_size: r_q.area_size,
                  walk_kind: WK_L1_NONE, l1_descriptor: '0, l2_descriptor: '0};
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (l1_rd_q[1:0] == DT_FAULT) begin
          if (alloc_q >= ALLOC_W'(L2_TABLES)) begin
            out_d.status = ST_NOPOOL;
          end else begin
            l1_we   = 1'b1;
            l1_wd   = alloc_addr | 32'h1;
            l2_we   = 1'b1;
            l2_wa   = {alloc_q[TBL_W-1:0], r_q.virt_addr[19:12]};
            alloc_d = alloc_q + 1'b1;
            done_d  = 1'b0;
            state_d = S_STEP;
          end
        end else if (l1_rd_q[1:0] == DT_COARSE && in_pool) begin
          l2_we   = 1'b1;
          done_d  = 1'b0;
          state_d = S_STEP;
        end
        if (!done_d) begin
          r_d.virt_addr = r_q.virt_addr + 32'h0000_1000;
          r_d.phys_addr = r_q.phys_addr + 32'h0000_1000;
          r_d.area_size = r_q.area_size - 32'h0000_1000;
        end
      end
      S_RD_L1: state_d = S_RD_L2;
      S_RD_L2: begin
        out_d = '{status: ST_OK, remaining_size: '0, walk_kind: WK_L1_NONE,
                  l1_descriptor: l1_rd_q, l2_descriptor: '0};
        done_d  = 1'b1;
        state_d = S_IDLE;
        unique case (l1_rd_q[1:0])
          2'd0: out_d.walk_kind = WK_L1_NONE;
          2'd2: out_d.walk_kind = WK_SECTION;
          2'd3: out_d.walk_kind = WK_RESERVED;
          default: begin
            out_d.walk_kind = WK_COARSE;
            if (in_pool) begin
              done_d  = 1'b0;
              state_d = S_RD_FIN;
            end
          end
        endcase
      end
      S_RD_FIN: begin
        out_d.l2_descriptor = l2_rd_q;
        unique case (l2_rd_q[1:0])
          2'd0:    out_d.walk_kind = WK_L2_NONE;
          2'd1:    out_d.walk_kind = WK_LARGE;
          default: out_d.walk_kind = WK_PAGE;
        endcase
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign req_i.ready   = (state_q == S_IDLE) && !done_q;
  assign rsp_o.valid   = done_q;
  assign rsp_o.payload = out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
      clr_q   <= '0;
      alloc_q <= '0;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      clr_q   <= clr_d;
      alloc_q <= alloc_d;
      if (cfg_we_i) base_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    out_q <= out_d;
  end

  // First-level table
  always_ff @(posedge clk_i) begin
    if (l1_we) l1_mem[l1_wa] <= l1_wd;
    l1_rd_q <= l1_mem[r_q.virt_addr[31:20]];
  end

  // Second-level pool
  always_ff @(posedge clk_i) begin
    if (l2_we) l2_mem[l2_wa] <= l2_wd;
    l2_rd_q <= l2_mem[l2_ra];
  end

  // Checks
  a_alloc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_q <= ALLOC_W'(L2_TABLES)) else $error("pool count overrun");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready) else $error("second accept");
  a_fail_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.payload.status != ST_OK) |->
    rsp_o.payload.remaining_size != '0) else $error("fault with no remainder");
  a_alloc_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alloc_q != $past(alloc_q)) |-> $past(state_q) == S_PG_L1)
    else $error("allocation outside page step");

endmodule
`default_nettype wire
